FILE: rtl/core/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types and constants of the life generation row stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

  // Width of the row on the stream ports.
  localparam int unsigned ROW_W  = 64;
  // Width of the column count register.
  localparam int unsigned COLS_W = 7;

  // Column count after reset and the smallest usable column count.
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
  localparam logic [COLS_W-1:0] COLS_MIN   = 7'd3;

  // How many rows of the current grid have been taken, saturating at two.
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  // One result word.
  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic             last_of_run;
    logic             grid_done;
  } res_t;

  // Up to two result words pushed into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/core/lgrs_evolve.sv
// ----------------------------------------------------------------------------
// lgrs_evolve
// One generation step of a row: a neighbor count and the B3/S23 rule per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_evolve #(
  parameter int unsigned W = 64
) (
  input  wire logic [W-1:0]                above,
  input  wire logic [W-1:0]                mid,
  input  wire logic [W-1:0]                below,
  input  wire logic [lgrs_pkg::COLS_W-1:0] cols,
  output logic      [W-1:0]                next_row
);
  import lgrs_pkg::*;

  // Rows padded with a dead cell on each side so every lane sees three taps.
  logic [W+1:0] ab_x;
  logic [W+1:0] md_x;
  logic [W+1:0] bl_x;

  assign ab_x = {1'b0, above, 1'b0};
  assign md_x = {1'b0, mid,   1'b0};
  assign bl_x = {1'b0, below, 1'b0};

  // Each lane counts its eight neighbors and applies the rule when interior.
  for (genvar c = 0; c < W; c++) begin : g_lane
    logic [3:0] nbr;
    logic       inner;

    assign nbr = 4'(ab_x[c]) + 4'(ab_x[c+1]) + 4'(ab_x[c+2])
               + 4'(md_x[c]) + 4'(md_x[c+2])
               + 4'(bl_x[c]) + 4'(bl_x[c+1]) + 4'(bl_x[c+2]);

    assign inner = (c >= 1) && (COLS_W'(c + 1) < cols);

    always_comb begin
      if (!inner) begin
        next_row[c] = mid[c];
      end else if (nbr == 4'd3) begin
        next_row[c] = 1'b1;
      end else if (nbr == 4'd2) begin
        next_row[c] = mid[c];
      end else begin
        next_row[c] = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lgrs_out_queue.sv
// ----------------------------------------------------------------------------
// lgrs_out_queue
// Two-entry result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_out_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lgrs_pkg::push_t push,
  output logic [1:0]           space,
  output lgrs_pkg::res_t       head,
  output logic                 head_valid,
  input  wire logic            head_ready
);
  import lgrs_pkg::*;

  res_t       q_r [2];
  res_t       q_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_a;
  logic       pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  assign pop        = head_valid && head_ready;

  // Room left for new words once this cycle's pop is counted.
  assign space = 2'd2 - cnt_r + 2'(pop);

  // Shift out the popped word, then append the pushed words behind the rest.
  always_comb begin
    cnt_a = cnt_r - 2'(pop);
    if (pop) begin
      q_nxt[0] = q_r[1];
    end else begin
      q_nxt[0] = q_r[0];
    end
    q_nxt[1] = q_r[1];
    case (cnt_a)
      2'd0: begin
        if (push.cnt != 2'd0) begin
          q_nxt[0] = push.r0;
        end
        if (push.cnt == 2'd2) begin
          q_nxt[1] = push.r1;
        end
      end
      2'd1: begin
        if (push.cnt != 2'd0) begin
          q_nxt[1] = push.r0;
        end
      end
      default: begin
      end
    endcase
    cnt_nxt = cnt_a + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

endmodule

`default_nettype wire

FILE: rtl/core/life_generation_row_stepper_core.sv
// ----------------------------------------------------------------------------
// life_generation_row_stepper_core
// Streams a life grid row by row and returns the next generation, one row
// behind the input, with border rows and columns passed through unchanged.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Words                       | Handshake
//  --------+-----------+-----------------------------+----------------------
//  in_     | input     | grid row, tlast = last row  | tvalid / tready
//  out_    | output    | next row, tlast, tuser      | tvalid / tready
//  cfg_    | input     | column count (7 bits)       | cfg_wr_en, no wait
//
// An accepted row is held in the input register, where the neighbor count
// and rule are evaluated, and is then written into a two-entry result queue.
// One row is taken every cycle while the queue has room for its results; a
// grid's final row makes two result words, one in a one-row grid; the queue
// absorbs the extra word. Reset clears the row count, the queue and the input
// register's valid flag, and sets the column count to 64. A stalled output
// stops the input register once the queue has no room for the words the waiting row makes.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_row_stepper_core #(
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input stream. tdata: row_cells [63:0]. tlast: last_row.
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [lgrs_pkg::ROW_W-1:0]   in_tdata,
  input  wire logic                         in_tlast,
  // Result stream. tdata: next_row [63:0]. tlast: last_of_run. tuser: grid_done.
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [lgrs_pkg::ROW_W-1:0]   out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser,
  // Column count register.
  input  wire logic                         cfg_wr_en,
  input  wire logic [lgrs_pkg::COLS_W-1:0]  cfg_wr_data
);
  import lgrs_pkg::*;

  localparam int unsigned        W        = MAX_COLUMNS;
  localparam logic [COLS_W-1:0]  COLS_MAX = COLS_W'(MAX_COLUMNS);

  // Configuration and derived column mask.
  logic [COLS_W-1:0] cols_r;
  logic [COLS_W-1:0] cols_eff;
  logic [W-1:0]      col_mask;

  // Input register.
  logic              stg_v_r;
  logic [W-1:0]      stg_row_r;
  logic              stg_last_r;
  logic              stg_fire;
  logic              in_fire;

  // Row history.
  logic [W-1:0]      older_r;
  logic [W-1:0]      older_nxt;
  logic [W-1:0]      middle_r;
  logic [W-1:0]      middle_nxt;
  logic [1:0]        seen_r;
  logic [1:0]        seen_nxt;

  logic [W-1:0]      older_m;
  logic [W-1:0]      middle_m;
  logic [W-1:0]      evolved;

  push_t             push_want;
  push_t             push;
  logic [1:0]        space;
  res_t              head;

  // Column count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
    end else if (cfg_wr_en) begin
      cols_r <= cfg_wr_data;
    end
  end

  // Clamp the column count to the usable range.
  always_comb begin
    if (cols_r < COLS_MIN) begin
      cols_eff = COLS_MIN;
    end else if (cols_r > COLS_MAX) begin
      cols_eff = COLS_MAX;
    end else begin
      cols_eff = cols_r;
    end
  end

  for (genvar c = 0; c < W; c++) begin : g_mask
    assign col_mask[c] = (COLS_W'(c) < cols_eff);
  end

  // Input register: holds one row until the queue has room for its results.
  assign in_tready = !stg_v_r || stg_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tready) begin
      stg_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_row_r  <= in_tdata[W-1:0];
      stg_last_r <= in_tlast;
    end
  end

  // Stored rows are masked again in case the column count has shrunk.
  assign older_m  = older_r & col_mask;
  assign middle_m = middle_r & col_mask;

  lgrs_evolve #(
    .W (W)
  ) u_evolve (
    .above    (older_m),
    .mid      (middle_m),
    .below    (stg_row_r & col_mask),
    .cols     (cols_eff),
    .next_row (evolved)
  );

  // Results of the waiting row and the history it leaves behind.
  always_comb begin
    push_want.cnt = 2'd0;
    push_want.r0  = '0;
    push_want.r1  = '0;
    older_nxt     = older_r;
    middle_nxt    = middle_r;
    seen_nxt      = seen_r;
    case (seen_r)
      SEEN_NONE: begin
        if (stg_last_r) begin
          push_want.cnt            = 2'd1;
          push_want.r0.next_row    = ROW_W'(stg_row_r & col_mask);
          push_want.r0.last_of_run = 1'b1;
          push_want.r0.grid_done   = 1'b1;
        end else begin
          middle_nxt = stg_row_r & col_mask;
          seen_nxt   = SEEN_ONE;
        end
      end
      SEEN_ONE, SEEN_TWO: begin
        if (seen_r == SEEN_ONE) begin
          push_want.r0.next_row = ROW_W'(middle_m);
        end else begin
          push_want.r0.next_row = ROW_W'(evolved & col_mask);
        end
        push_want.r0.last_of_run = !stg_last_r;
        push_want.r0.grid_done   = 1'b0;
        if (stg_last_r) begin
          push_want.cnt            = 2'd2;
          push_want.r1.next_row    = ROW_W'(stg_row_r & col_mask);
          push_want.r1.last_of_run = 1'b1;
          push_want.r1.grid_done   = 1'b1;
          seen_nxt                 = SEEN_NONE;
        end else begin
          push_want.cnt = 2'd1;
          older_nxt     = middle_r;
          middle_nxt    = stg_row_r & col_mask;
          seen_nxt      = SEEN_TWO;
        end
      end
      default: begin
        seen_nxt = SEEN_NONE;
      end
    endcase
  end

  // The row moves on only when the queue can take every word it makes.
  assign stg_fire = stg_v_r && (push_want.cnt <= space);

  always_comb begin
    push = push_want;
    if (!stg_fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= SEEN_NONE;
    end else if (stg_fire) begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire) begin
      older_r  <= older_nxt;
      middle_r <= middle_nxt;
    end
  end

  lgrs_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .head       (head),
    .head_valid (out_tvalid),
    .head_ready (out_tready)
  );

  assign out_tdata = head.next_row;
  assign out_tlast = head.last_of_run;
  assign out_tuser = head.grid_done;

endmodule

`default_nettype wire
